// File: src/accumulator_cpu_step_top_macros.svh
// Assertion macros used by the accumulator CPU port checker.
`ifndef ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH

// Checked in the cycle after the antecedent, outside reset.
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked in the cycle after the antecedent, reset included.
`define ACS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/acs_pkg.sv
// Shared constants, codes and types of the accumulator CPU step block.
`timescale 1ns / 1ps
package acs_pkg;

  localparam int WORD_W     = 8;
  localparam int DATA_DEPTH = 256;
  localparam int ADDR_W     = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int STEPS      = WORD_W;
  localparam int CNT_W      = $clog2(STEPS);
  localparam int FLAGS_W    = 3;

  localparam int FLG_Z = 0;
  localparam int FLG_C = 1;
  localparam int FLG_V = 2;

  typedef enum logic [7:0] {
    OP_LOADMEM = 8'd0,
    OP_LOADVAL = 8'd1,
    OP_STORE   = 8'd2,
    OP_ADD     = 8'd3,
    OP_SUB     = 8'd4,
    OP_MUL     = 8'd5,
    OP_DIV     = 8'd6,
    OP_INC     = 8'd7,
    OP_DEC     = 8'd8,
    OP_AND     = 8'd9,
    OP_OR      = 8'd10,
    OP_NOT     = 8'd11,
    OP_JMP     = 8'd12,
    OP_JZ      = 8'd13,
    OP_JNZ     = 8'd14,
    OP_JG      = 8'd15,
    OP_JL      = 8'd16,
    OP_JGE     = 8'd17,
    OP_JLE     = 8'd18,
    OP_HLT     = 8'd19
  } opcode_t;

  typedef enum logic [1:0] {
    RUN_OK    = 2'd0,
    RUN_HALT  = 2'd1,
    RUN_DIV0  = 2'd2,
    RUN_BADOP = 2'd3
  } run_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOT
  } alu_op_t;

  // Operands are one bit wider than a word so that the divider can subtract
  // a shifted remainder of up to nine bits.
  typedef struct packed {
    alu_op_t         op;
    logic [WORD_W:0] a;
    logic [WORD_W:0] b;
  } alu_req_t;

endpackage

// File: src/acs_if.sv
// Valid/ready channel interfaces for instruction words and result words.
`timescale 1ns / 1ps
interface acs_in_if;
  logic                       valid;
  logic                       ready;
  logic [acs_pkg::WORD_W-1:0] opcode;
  logic [acs_pkg::WORD_W-1:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface acs_out_if;
  logic                        valid;
  logic                        ready;
  logic [acs_pkg::WORD_W-1:0]  next_pc;
  logic [acs_pkg::WORD_W-1:0]  accumulator;
  logic [acs_pkg::FLAGS_W-1:0] flags;
  logic [1:0]                  run_status;

  modport source (output valid, output next_pc, output accumulator, output flags,
                  output run_status, input ready);
  modport sink   (input valid, input next_pc, input accumulator, input flags,
                  input run_status, output ready);
endinterface

// File: src/acs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/acs_alu.sv
// Shared adder, subtractor and logic unit used by the execute, multiply and divide steps.
`timescale 1ns / 1ps
module acs_alu (
  input  acs_pkg::alu_req_t         req,
  output logic [acs_pkg::WORD_W+1:0] res
);

  localparam int RES_W = acs_pkg::WORD_W + 2;

  // For a subtraction the top bit is the borrow, set when a is below b.
  always_comb begin
    case (req.op)
      acs_pkg::ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      acs_pkg::ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      acs_pkg::ALU_AND: res = {1'b0, req.a & req.b};
      acs_pkg::ALU_OR:  res = {1'b0, req.a | req.b};
      acs_pkg::ALU_NOT: res = {1'b0, ~req.a};
      default:          res = RES_W'(0);
    endcase
  end

endmodule

// File: src/accumulator_cpu_step_top.sv
// Accumulator CPU: one instruction word in, one result word out.
// The instruction word is accepted in IDLE, executed in EXEC and its result word is loaded
// into the output register from RESP once that is free; MUL and a DIV by a non-zero byte pass
// through MUL or DIV, where the shared adder runs one shift-add or shift-subtract step per cycle
// over eight steps. A new word is taken only once the last result word is registered.
// Reset (synchronous, active low) clears the control and architectural registers and the data memory valid bits.
`timescale 1ns / 1ps
module accumulator_cpu_step_top (
  input  logic      clk,
  input  logic      rst_n,
  acs_in_if.sink    in_chan,
  acs_out_if.source out_chan
);

  localparam int W = acs_pkg::WORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_RESP
  } state_t;

  state_t                          state_r, state_nxt;
  logic [W-1:0]                    op_r, op_nxt;
  logic [W-1:0]                    arg_r, arg_nxt;
  logic                            mok_r, mok_nxt;
  logic [W-1:0]                    acc_r, acc_nxt;
  logic [W-1:0]                    pc_r, pc_nxt;
  logic [acs_pkg::FLAGS_W-1:0]     flag_r, flag_nxt;
  acs_pkg::run_t                   stop_r, stop_nxt;
  logic [W-1:0]                    hi_r, hi_nxt;
  logic [W-1:0]                    lo_r, lo_nxt;
  logic [acs_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [acs_pkg::DATA_DEPTH-1:0]  vld_r, vld_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [W-1:0]                    out_pc_r, out_pc_nxt;
  logic [W-1:0]                    out_acc_r, out_acc_nxt;
  logic [acs_pkg::FLAGS_W-1:0]     out_flag_r, out_flag_nxt;
  logic [1:0]                      out_stat_r, out_stat_nxt;

  acs_pkg::alu_req_t               alu_req;
  logic [W+1:0]                    alu_res;

  logic                            ram_we;
  logic                            ram_re;
  logic [W-1:0]                    ram_rdata;
  logic [acs_pkg::ADDR_W-1:0]      in_addr;
  logic [acs_pkg::ADDR_W-1:0]      arg_addr;
  logic                            in_range;
  logic                            arg_range;
  logic [W-1:0]                    mem_val;
  logic [W-1:0]                    pc_inc;
  logic [W-1:0]                    target;
  logic                            lt;
  logic                            eq;
  logic                            last_step;
  logic [W:0]                      mul_sum;
  logic [W:0]                      rem_sh;
  logic                            qbit;
  logic [W-1:0]                    rem_new;
  logic [W-1:0]                    acc_n;
  logic [W-1:0]                    pc_n;
  logic                            commit;

  assign in_addr   = in_chan.operand[acs_pkg::ADDR_W-1:0];
  assign arg_addr  = arg_r[acs_pkg::ADDR_W-1:0];
  assign in_range  = {1'b0, in_chan.operand} < (W+1)'(acs_pkg::DATA_DEPTH);
  assign arg_range = {1'b0, arg_r} < (W+1)'(acs_pkg::DATA_DEPTH);

  // A byte never stored since reset reads as zero, as does an address
  // beyond the memory.
  assign mem_val   = mok_r ? ram_rdata : '0;
  assign pc_inc    = pc_r + W'(1);
  assign target    = {1'b0, arg_r[W-1:1]};
  assign lt        = alu_res[W+1];
  assign eq        = (acc_r == mem_val);
  assign last_step = (cnt_r == acs_pkg::CNT_W'(acs_pkg::STEPS - 1));
  assign mul_sum   = lo_r[0] ? alu_res[W:0] : {1'b0, hi_r};
  assign rem_sh    = {hi_r, lo_r[W-1]};
  assign qbit      = !alu_res[W+1];
  assign rem_new   = qbit ? alu_res[W-1:0] : rem_sh[W-1:0];

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_vld_r;
  assign out_chan.next_pc     = out_pc_r;
  assign out_chan.accumulator = out_acc_r;
  assign out_chan.flags       = out_flag_r;
  assign out_chan.run_status  = out_stat_r;

  acs_ram #(
    .WIDTH (W),
    .DEPTH (acs_pkg::DATA_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (arg_addr),
    .wdata (acc_r),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  acs_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = acs_pkg::ALU_ADD;
    alu_req.a  = {1'b0, acc_r};
    alu_req.b  = {1'b0, mem_val};
    case (state_r)
      ST_EXEC: begin
        case (op_r)
          acs_pkg::OP_INC: alu_req.b = (W+1)'(1);
          acs_pkg::OP_DEC: begin
            alu_req.op = acs_pkg::ALU_SUB;
            alu_req.b  = (W+1)'(1);
          end
          acs_pkg::OP_AND: alu_req.op = acs_pkg::ALU_AND;
          acs_pkg::OP_OR:  alu_req.op = acs_pkg::ALU_OR;
          acs_pkg::OP_NOT: alu_req.op = acs_pkg::ALU_NOT;
          acs_pkg::OP_ADD: alu_req.op = acs_pkg::ALU_ADD;
          default:         alu_req.op = acs_pkg::ALU_SUB;
        endcase
      end
      ST_MUL: alu_req.a = {1'b0, hi_r};
      ST_DIV: begin
        alu_req.op = acs_pkg::ALU_SUB;
        alu_req.a  = rem_sh;
      end
      default: alu_req.op = acs_pkg::ALU_ADD;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    arg_nxt      = arg_r;
    mok_nxt      = mok_r;
    acc_nxt      = acc_r;
    pc_nxt       = pc_r;
    flag_nxt     = flag_r;
    stop_nxt     = stop_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    cnt_nxt      = cnt_r;
    vld_nxt      = vld_r;
    out_vld_nxt  = out_vld_r && !out_chan.ready;
    out_pc_nxt   = out_pc_r;
    out_acc_nxt  = out_acc_r;
    out_flag_nxt = out_flag_r;
    out_stat_nxt = out_stat_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    acc_n        = acc_r;
    pc_n         = pc_inc;
    commit       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt  = in_chan.opcode;
          arg_nxt = in_chan.operand;
          mok_nxt = in_range && vld_r[in_addr];
          ram_re  = 1'b1;
          // Once stopped, the word is answered with the frozen state.
          state_nxt = (stop_r == acs_pkg::RUN_OK) ? ST_EXEC : ST_RESP;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RESP;
        commit    = 1'b1;
        case (op_r)
          acs_pkg::OP_LOADMEM: acc_n = mem_val;
          acs_pkg::OP_LOADVAL: acc_n = arg_r;
          acs_pkg::OP_STORE: begin
            if (arg_range) begin
              ram_we            = 1'b1;
              vld_nxt[arg_addr] = 1'b1;
            end
          end
          acs_pkg::OP_ADD: begin
            acc_n = alu_res[W-1:0];
            if (alu_res[W]) begin
              flag_nxt[acs_pkg::FLG_C] = 1'b1;
            end
          end
          acs_pkg::OP_SUB, acs_pkg::OP_INC, acs_pkg::OP_DEC,
          acs_pkg::OP_AND, acs_pkg::OP_OR, acs_pkg::OP_NOT: begin
            acc_n = alu_res[W-1:0];
          end
          acs_pkg::OP_MUL: begin
            commit    = 1'b0;
            hi_nxt    = '0;
            lo_nxt    = acc_r;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
          acs_pkg::OP_DIV: begin
            commit = 1'b0;
            if (mem_val == '0) begin
              stop_nxt = acs_pkg::RUN_DIV0;
            end else begin
              hi_nxt    = '0;
              lo_nxt    = acc_r;
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
          end
          acs_pkg::OP_JMP: pc_n = target;
          acs_pkg::OP_JZ:  if (acc_r == '0) pc_n = target;
          acs_pkg::OP_JNZ: if (acc_r != '0) pc_n = target;
          acs_pkg::OP_JG:  if (!lt && !eq) pc_n = target;
          acs_pkg::OP_JL:  if (lt) pc_n = target;
          acs_pkg::OP_JGE: if (!lt) pc_n = target;
          acs_pkg::OP_JLE: if (lt || eq) pc_n = target;
          acs_pkg::OP_HLT: begin
            commit   = 1'b0;
            stop_nxt = acs_pkg::RUN_HALT;
          end
          default: begin
            commit   = 1'b0;
            stop_nxt = acs_pkg::RUN_BADOP;
          end
        endcase
      end

      // Shift-add multiply: the high byte collects partial sums while the
      // multiplier shifts out of the low byte.
      ST_MUL: begin
        hi_nxt  = mul_sum[W:1];
        lo_nxt  = {mul_sum[0], lo_r[W-1:1]};
        cnt_nxt = cnt_r + acs_pkg::CNT_W'(1);
        if (last_step) begin
          commit    = 1'b1;
          acc_n     = {mul_sum[0], lo_r[W-1:1]};
          state_nxt = ST_RESP;
          if (mul_sum[W:1] != '0) begin
            flag_nxt[acs_pkg::FLG_V] = 1'b1;
          end
        end
      end

      // Restoring divide: one quotient bit per step, dividend shifts out of
      // the low byte into the remainder.
      ST_DIV: begin
        hi_nxt  = rem_new;
        lo_nxt  = {lo_r[W-2:0], qbit};
        cnt_nxt = cnt_r + acs_pkg::CNT_W'(1);
        if (last_step) begin
          commit    = 1'b1;
          acc_n     = {lo_r[W-2:0], qbit};
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt  = 1'b1;
          out_pc_nxt   = pc_r;
          out_acc_nxt  = acc_r;
          out_flag_nxt = flag_r;
          out_stat_nxt = stop_r;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (commit) begin
      acc_nxt                  = acc_n;
      pc_nxt                   = pc_n;
      flag_nxt[acs_pkg::FLG_Z] = (acc_n == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= '0;
      pc_r      <= '0;
      flag_r    <= '0;
      stop_r    <= acs_pkg::RUN_OK;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      pc_r      <= pc_nxt;
      flag_r    <= flag_nxt;
      stop_r    <= stop_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r       <= op_nxt;
    arg_r      <= arg_nxt;
    mok_r      <= mok_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    cnt_r      <= cnt_nxt;
    out_pc_r   <= out_pc_nxt;
    out_acc_r  <= out_acc_nxt;
    out_flag_r <= out_flag_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

// File: src/acs_chk.sv
// Port-level checker for the accumulator CPU, bound to the top level.
`timescale 1ns / 1ps
`include "accumulator_cpu_step_top_macros.svh"
module acs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [acs_pkg::WORD_W-1:0]  out_next_pc,
  input logic [acs_pkg::WORD_W-1:0]  out_accumulator,
  input logic [acs_pkg::FLAGS_W-1:0] out_flags,
  input logic [1:0]                  out_run_status
);

  logic [2*acs_pkg::WORD_W+acs_pkg::FLAGS_W+1:0] out_word;

  assign out_word = {out_next_pc, out_accumulator, out_flags, out_run_status};

  // No result word may be offered straight after reset.
  `ACS_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "result word valid after reset")

  // An accepted instruction keeps the input closed for at least the next cycle.
  `ACS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input reopened early")

  // A stalled result word holds.
  `ACS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled word changed")

  // A valid stop status is held by any word that is valid straight after it.
  `ACS_ASSERT_NEXT(a_stop_sticky, out_valid && out_run_status != acs_pkg::RUN_OK, !out_valid || out_run_status == $past(out_run_status), "stop status changed")

endmodule

bind accumulator_cpu_step_top acs_chk u_acs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_next_pc     (out_chan.next_pc),
  .out_accumulator (out_chan.accumulator),
  .out_flags       (out_chan.flags),
  .out_run_status  (out_chan.run_status)
);

// File: test/acs_result_checker.sv
// Checker that predicts the result word of every accepted instruction word and compares it.
`timescale 1ns / 1ps
module acs_result_checker (
  input  logic clk,
  input  logic rst_n,
  acs_in_if    in_mon,
  acs_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [acs_pkg::WORD_W-1:0]  next_pc;
    logic [acs_pkg::WORD_W-1:0]  accumulator;
    logic [acs_pkg::FLAGS_W-1:0] flags;
    acs_pkg::run_t               run_status;
  } outcome_t;

  // Architectural state as the block should hold it.
  logic [acs_pkg::WORD_W-1:0]  acc_q;
  logic [acs_pkg::WORD_W-1:0]  pc_q;
  logic [acs_pkg::FLAGS_W-1:0] flag_q;
  acs_pkg::run_t               run_q;
  logic [acs_pkg::WORD_W-1:0]  mem_q [acs_pkg::DATA_DEPTH];

  outcome_t outcome_queue [$];

  task automatic execute_word(input logic [7:0] op, input logic [7:0] arg);
    logic [acs_pkg::WORD_W-1:0] a;
    logic [acs_pkg::WORD_W-1:0] m;
    logic [acs_pkg::WORD_W-1:0] nxt;
    logic [acs_pkg::WORD_W:0]   sum;
    logic [15:0]                prod;
    logic                       retire;
    if (run_q == acs_pkg::RUN_OK) begin
      a      = acc_q;
      m      = (arg < acs_pkg::DATA_DEPTH) ? mem_q[arg] : '0;
      nxt    = pc_q + 8'd1;
      retire = 1'b1;
      case (op)
        acs_pkg::OP_LOADMEM: a = m;
        acs_pkg::OP_LOADVAL: a = arg;
        acs_pkg::OP_STORE:   if (arg < acs_pkg::DATA_DEPTH) mem_q[arg] = a;
        acs_pkg::OP_ADD: begin
          sum = {1'b0, a} + {1'b0, m};
          if (sum[acs_pkg::WORD_W]) flag_q[acs_pkg::FLG_C] = 1'b1;
          a = sum[acs_pkg::WORD_W-1:0];
        end
        acs_pkg::OP_SUB: a = a - m;
        acs_pkg::OP_MUL: begin
          prod = {8'd0, a} * {8'd0, m};
          if (prod[15:8] != 8'd0) flag_q[acs_pkg::FLG_V] = 1'b1;
          a = prod[7:0];
        end
        acs_pkg::OP_DIV: begin
          if (m == '0) begin
            run_q  = acs_pkg::RUN_DIV0;
            retire = 1'b0;
          end else begin
            a = a / m;
          end
        end
        acs_pkg::OP_INC: a = a + 8'd1;
        acs_pkg::OP_DEC: a = a - 8'd1;
        acs_pkg::OP_AND: a = a & m;
        acs_pkg::OP_OR:  a = a | m;
        acs_pkg::OP_NOT: a = ~a;
        acs_pkg::OP_JMP: nxt = arg >> 1;
        acs_pkg::OP_JZ:  if (a == '0) nxt = arg >> 1;
        acs_pkg::OP_JNZ: if (a != '0) nxt = arg >> 1;
        acs_pkg::OP_JG:  if (a > m) nxt = arg >> 1;
        acs_pkg::OP_JL:  if (a < m) nxt = arg >> 1;
        acs_pkg::OP_JGE: if (a >= m) nxt = arg >> 1;
        acs_pkg::OP_JLE: if (a <= m) nxt = arg >> 1;
        acs_pkg::OP_HLT: begin
          run_q  = acs_pkg::RUN_HALT;
          retire = 1'b0;
        end
        default: begin
          run_q  = acs_pkg::RUN_BADOP;
          retire = 1'b0;
        end
      endcase
      // A stopping instruction leaves even the zero flag alone.
      if (retire) begin
        acc_q                  = a;
        pc_q                   = nxt;
        flag_q[acs_pkg::FLG_Z] = (a == '0);
      end
    end
    outcome_queue.push_back(outcome_t'{pc_q, acc_q, flag_q, run_q});
  endtask

  always @(posedge clk) begin : compare_proc
    outcome_t want;
    if (!rst_n) begin
      acc_q      = '0;
      pc_q       = '0;
      flag_q     = '0;
      run_q      = acs_pkg::RUN_OK;
      fail_count = 0;
      foreach (mem_q[i]) mem_q[i] = '0;
      outcome_queue.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) execute_word(in_mon.opcode, in_mon.operand);
      if (out_mon.valid && out_mon.ready) begin
        if (outcome_queue.size() == 0) begin
          $error("result word with no instruction word outstanding");
          fail_count++;
        end else begin
          want = outcome_queue.pop_front();
          if (out_mon.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, got %0d", want.next_pc, out_mon.next_pc);
            fail_count++;
          end
          if (out_mon.accumulator !== want.accumulator) begin
            $error("accumulator: expected %0d, got %0d", want.accumulator,
                   out_mon.accumulator);
            fail_count++;
          end
          if (out_mon.flags !== want.flags) begin
            $error("flags: expected %b, got %b", want.flags, out_mon.flags);
            fail_count++;
          end
          if (out_mon.run_status !== want.run_status) begin
            $error("run_status: expected %0d, got %0d", want.run_status,
                   out_mon.run_status);
            fail_count++;
          end
        end
      end
    end
    pending_count = outcome_queue.size();
  end

endmodule

// File: test/tb_accumulator_cpu_step_top.sv
// Testbench top: clock, reset, instruction word stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_accumulator_cpu_step_top;

  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_END  = 1800;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  acs_in_if  in_chan ();
  acs_out_if out_chan ();

  int fail_count;
  int pending_count;
  int words_sent = 0;

  bit hold_req = 1'b0;
  bit stall_en = 1'b1;
  // Addresses known to hold a non-zero byte, so that a divide there is safe.
  bit div_safe [acs_pkg::DATA_DEPTH];

  accumulator_cpu_step_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  acs_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      1:       return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high into the next word.
  task automatic send_word(input logic [7:0] op, input logic [7:0] arg);
    in_chan.valid   <= 1'b1;
    in_chan.opcode  <= op;
    in_chan.operand <= arg;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic pause_offer(input int cycles);
    if (cycles > 0) begin
      in_chan.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic send_div();
    logic [7:0] addr;
    int tries;
    addr = pick_operand();
    for (tries = 0; tries < 4 && !div_safe[addr]; tries++) addr = pick_operand();
    if (!div_safe[addr]) begin
      send_word(acs_pkg::OP_LOADVAL, 8'($urandom_range(1, 255)));
      send_word(acs_pkg::OP_STORE, addr);
      div_safe[addr] = 1'b1;
    end
    send_word(acs_pkg::OP_DIV, addr);
  endtask

  task automatic random_word(input bit allow_jump);
    logic [7:0] op;
    logic [7:0] arg;
    op  = 8'($urandom_range(0, allow_jump ? 18 : 11));
    arg = pick_operand();
    if (op == acs_pkg::OP_DIV) begin
      send_div();
    end else begin
      if (op == acs_pkg::OP_STORE) div_safe[arg] = 1'b0;
      send_word(op, arg);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, and quiet stretches.
  initial begin : result_sink
    bit phase;
    int left;
    int held;
    out_chan.ready = 1'b0;
    phase = 1'b1;
    left  = 0;
    held  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        held++;
        out_chan.ready <= 1'b0;
      end else if (!stall_en) begin
        out_chan.ready <= 1'b1;
      end else begin
        if (left == 0) begin
          phase = !phase;
          left  = phase ? $urandom_range(1, 10) : $urandom_range(1, 4);
        end
        left--;
        out_chan.ready <= phase;
      end
    end
  end

  initial begin : stimulus
    int stop_kind;
    bit paused_once;
    logic [7:0] addr;
    paused_once     = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.opcode  = '0;
    in_chan.operand = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, every operation but JMP and HLT, carry and overflow, zero flag.
    send_word(acs_pkg::OP_LOADVAL, 8'h00);
    send_word(acs_pkg::OP_STORE,   8'h00);
    send_word(acs_pkg::OP_LOADVAL, 8'hFF);
    send_word(acs_pkg::OP_STORE,   8'hFF);
    div_safe[255] = 1'b1;
    send_word(acs_pkg::OP_ADD,     8'hFF);
    send_word(acs_pkg::OP_LOADMEM, 8'hFF);
    send_word(acs_pkg::OP_INC,     8'h00);
    send_word(acs_pkg::OP_DEC,     8'h00);
    send_word(acs_pkg::OP_MUL,     8'hFF);
    send_word(acs_pkg::OP_SUB,     8'hFF);
    send_word(acs_pkg::OP_DIV,     8'hFF);
    send_word(acs_pkg::OP_NOT,     8'h00);
    send_word(acs_pkg::OP_AND,     8'h00);
    send_word(acs_pkg::OP_OR,      8'hFF);
    send_word(acs_pkg::OP_LOADMEM, 8'h80);
    send_word(acs_pkg::OP_JZ,      8'hFF);
    send_word(acs_pkg::OP_LOADVAL, 8'hFF);
    send_word(acs_pkg::OP_JZ,      8'h08);
    send_word(acs_pkg::OP_JNZ,     8'h00);
    send_word(acs_pkg::OP_JG,      8'h00);
    send_word(acs_pkg::OP_JL,      8'hFF);
    send_word(acs_pkg::OP_JGE,     8'hFF);
    send_word(acs_pkg::OP_JLE,     8'h00);
    send_word(acs_pkg::OP_LOADVAL, 8'h01);
    send_word(acs_pkg::OP_JLE,     8'hFF);

    // Straight-line code from the top of the jump range, long enough for the
    // program counter to wrap past 255.
    send_word(acs_pkg::OP_JMP, 8'hFF);
    repeat (140) random_word(1'b0);

    while (words_sent < RANDOM_END) begin
      stall_en = !(words_sent >= 1200 && words_sent < 1400);
      if (!hold_req && words_sent > 600) hold_req = 1'b1;
      repeat ($urandom_range(1, 12)) random_word(1'b1);
      if (!paused_once && words_sent > 1000) begin
        in_chan.valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
        paused_once = 1'b1;
      end else if (stall_en) begin
        pause_offer($urandom_range(0, 6));
      end
    end
    stall_en = 1'b1;

    // Only one stop is possible per run, so the seed picks which one.
    stop_kind = $urandom_range(0, 2);
    case (stop_kind)
      0: send_word(acs_pkg::OP_HLT, 8'($urandom_range(0, 255)));
      1: begin
        addr = 8'($urandom_range(0, 255));
        send_word(acs_pkg::OP_LOADVAL, 8'h00);
        send_word(acs_pkg::OP_STORE, addr);
        div_safe[addr] = 1'b0;
        send_word(acs_pkg::OP_DIV, addr);
      end
      default: send_word(8'($urandom_range(acs_pkg::OP_HLT + 1, 255)),
                         8'($urandom_range(0, 255)));
    endcase
    // Once stopped, every word is ignored but still answered with the frozen state.
    repeat (24) begin
      send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      pause_offer($urandom_range(0, 3));
    end

    in_chan.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/acs_pkg.sv
src/acs_if.sv
src/acs_ram.sv
src/acs_alu.sv
src/accumulator_cpu_step_top.sv
src/acs_chk.sv
test/acs_result_checker.sv
test/tb_accumulator_cpu_step_top.sv
